// ===== src/recursive_mutex_table_top_macros.svh =====
// assertion macros for the mutex table checker
`ifndef RECURSIVE_MUTEX_TABLE_TOP_MACROS_SVH
`define RECURSIVE_MUTEX_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define RMT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rmt_pkg.sv =====
`timescale 1ns / 1ps

package rmt_pkg;

   localparam int NUM_MUTEXES_DEF = 16;
   localparam int WAIT_DEPTH_DEF  = 8;

   localparam int ID_W    = 4;
   localparam int PID_W   = 8;
   localparam int VALUE_W = 8;
   localparam int COUNT_W = 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_DESTROY = 2'd1,
      OP_LOCK    = 2'd2,
      OP_UNLOCK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ERR     = 2'd1,
      ST_BLOCKED = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value;
      logic               woken_valid;
      logic [PID_W-1:0]   woken_pid;
   } result_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic wake;
      logic load;
   } dp_cmd_type;

   typedef struct packed {
      logic need_wake;
   } dp_status_type;

endpackage

// ===== src/rmt_obuf.sv =====
`timescale 1ns / 1ps

module rmt_obuf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rmt_pkg::result_type res_in,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rmt_pkg::result_type rsp_res,
   output logic               skid_full
);

   logic                out_v_ff, out_v_in;
   logic                skid_v_ff, skid_v_in;
   rmt_pkg::result_type out_ff, out_in;
   rmt_pkg::result_type skid_ff, skid_in;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || !rsp_stall) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_in    = skid_ff;
            skid_v_in = load;
            skid_in   = res_in;
         end else begin
            out_v_in = load;
            out_in   = res_in;
         end
      end else if (load) begin
         skid_v_in = 1'b1;
         skid_in   = res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_res   = out_ff;
   assign skid_full = skid_v_ff;

endmodule

// ===== src/rmt_dp.sv =====
`timescale 1ns / 1ps

module rmt_dp #(
   parameter int NUM_MUTEXES = rmt_pkg::NUM_MUTEXES_DEF,
   parameter int WAIT_DEPTH  = rmt_pkg::WAIT_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rmt_pkg::dp_cmd_type         cmd,
   input  logic [1:0]                  req_operation,
   input  logic [rmt_pkg::ID_W-1:0]    req_mutex_id,
   input  logic [rmt_pkg::PID_W-1:0]   req_requester_pid,
   input  logic                        req_requester_present,
   output rmt_pkg::dp_status_type      status,
   output rmt_pkg::result_type         res
);

   localparam int IW    = $clog2(NUM_MUTEXES);
   localparam int CW    = ((IW > rmt_pkg::ID_W) ? IW : rmt_pkg::ID_W) + 1;
   localparam int PCW   = IW + 1;
   localparam int WW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int WCW   = $clog2(WAIT_DEPTH + 1);
   localparam int AW    = $clog2(NUM_MUTEXES * WAIT_DEPTH);
   localparam int CNT_W = rmt_pkg::COUNT_W;
   localparam int PID_W = rmt_pkg::PID_W;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [PID_W-1:0] own;
      logic [WW-1:0]    wh;
      logic [WCW-1:0]   wc;
   } entry_type;

   function automatic logic [IW-1:0] pool_inc(input logic [IW-1:0] p);
      return (p == IW'(NUM_MUTEXES - 1)) ? '0 : p + IW'(1);
   endfunction

   function automatic logic [WW-1:0] wait_inc(input logic [WW-1:0] p);
      return (p == WW'(WAIT_DEPTH - 1)) ? '0 : p + WW'(1);
   endfunction

   function automatic logic [AW-1:0] wait_addr(input logic [IW-1:0] m,
                                               input logic [WW-1:0] s);
      return AW'(AW'(m) * AW'(WAIT_DEPTH) + AW'(s));
   endfunction

   // captured item
   rmt_pkg::op_type    op_ff;
   logic               id_ok_ff;
   logic [IW-1:0]      idx_ff;
   logic [PID_W-1:0]   pid_ff;
   logic               present_ff;

   // storage
   entry_type          entry_mem [NUM_MUTEXES];
   entry_type          ent_rd_ff;
   logic [IW-1:0]      pool_mem [NUM_MUTEXES];
   logic [IW-1:0]      pool_rd_ff;
   logic               pool_rd_vld_ff;
   logic [NUM_MUTEXES-1:0] pool_vld_ff;
   logic [IW-1:0]      pool_head_ff, pool_head_in;
   logic [PCW-1:0]     pool_cnt_ff, pool_cnt_in;
   logic [NUM_MUTEXES-1:0] alloc_ff;
   logic [PID_W-1:0]   wait_mem [NUM_MUTEXES * WAIT_DEPTH];
   logic [PID_W-1:0]   wait_rd_ff;

   logic [CW-1:0]      id_ext;
   logic [IW-1:0]      got;
   logic               alloc_cur;
   logic               lock_blocks;
   logic               unlock_ok;
   logic               need_wake;
   logic [CNT_W-1:0]   new_cnt;
   logic [IW:0]        tail_sum;
   logic [IW-1:0]      tail;
   logic [WW:0]        slot_sum;
   logic [WW-1:0]      slot;

   logic               ent_we;
   logic [IW-1:0]      ent_waddr;
   entry_type          ent_wdata;
   logic               pool_we;
   logic               wait_we;
   logic               wait_re;
   logic               alloc_set;
   logic               alloc_clr;
   logic [IW-1:0]      alloc_idx;

   assign id_ext = CW'(req_mutex_id);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= rmt_pkg::op_type'(req_operation);
         id_ok_ff   <= (id_ext < CW'(NUM_MUTEXES));
         idx_ff     <= id_ext[IW-1:0];
         pid_ff     <= req_requester_pid;
         present_ff <= req_requester_present;
      end
   end

   assign got         = pool_rd_vld_ff ? pool_rd_ff : pool_head_ff;
   assign alloc_cur   = id_ok_ff && alloc_ff[idx_ff];
   assign lock_blocks = (ent_rd_ff.cnt != '0) && (ent_rd_ff.own != pid_ff);
   assign new_cnt     = ent_rd_ff.cnt - CNT_W'(1);
   assign unlock_ok   = alloc_cur && (ent_rd_ff.cnt != '0) && present_ff
                        && (ent_rd_ff.own == pid_ff);
   assign need_wake   = (op_ff == rmt_pkg::OP_UNLOCK) && unlock_ok
                        && (new_cnt == '0) && (ent_rd_ff.wc != '0);
   assign status.need_wake = need_wake;

   // free pool tail and wait queue tail, both below twice the depth
   assign tail_sum = {1'b0, pool_head_ff} + pool_cnt_ff;
   assign tail     = (tail_sum >= (IW+1)'(NUM_MUTEXES))
                     ? IW'(tail_sum - (IW+1)'(NUM_MUTEXES)) : tail_sum[IW-1:0];
   assign slot_sum = (WW+1)'(ent_rd_ff.wh) + (WW+1)'(ent_rd_ff.wc);
   assign slot     = (slot_sum >= (WW+1)'(WAIT_DEPTH))
                     ? WW'(slot_sum - (WW+1)'(WAIT_DEPTH)) : slot_sum[WW-1:0];

   always_comb begin
      res.status      = rmt_pkg::ST_ERR;
      res.value       = '0;
      res.woken_valid = 1'b0;
      res.woken_pid   = '0;
      ent_we          = 1'b0;
      ent_waddr       = idx_ff;
      ent_wdata       = ent_rd_ff;
      pool_we         = 1'b0;
      wait_we         = 1'b0;
      wait_re         = 1'b0;
      alloc_set       = 1'b0;
      alloc_clr       = 1'b0;
      alloc_idx       = idx_ff;
      pool_head_in    = pool_head_ff;
      pool_cnt_in     = pool_cnt_ff;
      if (cmd.exec) begin
         unique case (op_ff)
            rmt_pkg::OP_ALLOC: begin
               if (pool_cnt_ff != '0) begin
                  res.status   = rmt_pkg::ST_OK;
                  res.value    = rmt_pkg::VALUE_W'(got);
                  alloc_set    = 1'b1;
                  alloc_idx    = got;
                  ent_we       = 1'b1;
                  ent_waddr    = got;
                  ent_wdata    = '0;
                  pool_head_in = pool_inc(pool_head_ff);
                  pool_cnt_in  = pool_cnt_ff - PCW'(1);
               end
            end
            rmt_pkg::OP_DESTROY: begin
               if (alloc_cur && (ent_rd_ff.cnt == '0)
                   && (pool_cnt_ff != PCW'(NUM_MUTEXES))) begin
                  res.status  = rmt_pkg::ST_OK;
                  alloc_clr   = 1'b1;
                  pool_we     = 1'b1;
                  pool_cnt_in = pool_cnt_ff + PCW'(1);
               end
            end
            rmt_pkg::OP_LOCK: begin
               if (alloc_cur && present_ff) begin
                  if (lock_blocks) begin
                     if (ent_rd_ff.wc != WCW'(WAIT_DEPTH)) begin
                        res.status   = rmt_pkg::ST_BLOCKED;
                        wait_we      = 1'b1;
                        ent_we       = 1'b1;
                        ent_wdata.wc = ent_rd_ff.wc + WCW'(1);
                     end
                  end else if (ent_rd_ff.cnt != rmt_pkg::COUNT_MAX) begin
                     res.status    = rmt_pkg::ST_OK;
                     res.value     = rmt_pkg::VALUE_W'(ent_rd_ff.cnt + CNT_W'(1));
                     ent_we        = 1'b1;
                     ent_wdata.own = pid_ff;
                     ent_wdata.cnt = ent_rd_ff.cnt + CNT_W'(1);
                  end
               end
            end
            rmt_pkg::OP_UNLOCK: begin
               if (unlock_ok) begin
                  if (need_wake) begin
                     wait_re = 1'b1;
                  end else begin
                     res.status    = rmt_pkg::ST_OK;
                     res.value     = rmt_pkg::VALUE_W'(new_cnt);
                     ent_we        = 1'b1;
                     ent_wdata.cnt = new_cnt;
                     ent_wdata.own = (new_cnt == '0) ? '0 : ent_rd_ff.own;
                  end
               end
            end
         endcase
      end else if (cmd.wake) begin
         // hand the mutex to the oldest waiter
         res.status      = rmt_pkg::ST_OK;
         res.value       = rmt_pkg::VALUE_W'(1);
         res.woken_valid = 1'b1;
         res.woken_pid   = wait_rd_ff;
         ent_we          = 1'b1;
         ent_wdata.cnt   = CNT_W'(1);
         ent_wdata.own   = wait_rd_ff;
         ent_wdata.wh    = wait_inc(ent_rd_ff.wh);
         ent_wdata.wc    = ent_rd_ff.wc - WCW'(1);
      end
   end

   // mutex entry table
   always_ff @(posedge clock) begin
      if (ent_we) begin
         entry_mem[ent_waddr] <= ent_wdata;
      end
      if (cmd.capture) begin
         ent_rd_ff <= entry_mem[id_ext[IW-1:0]];
      end
   end

   // free id pool
   always_ff @(posedge clock) begin
      if (pool_we) begin
         pool_mem[tail] <= idx_ff;
      end
      if (cmd.capture) begin
         pool_rd_ff <= pool_mem[pool_head_ff];
      end
   end

   // wait queues
   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem[wait_addr(idx_ff, slot)] <= pid_ff;
      end
      if (wait_re) begin
         wait_rd_ff <= wait_mem[wait_addr(idx_ff, ent_rd_ff.wh)];
      end
   end

   // pool slots not yet written hold their own index
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_vld_ff  <= '0;
         pool_head_ff <= '0;
         pool_cnt_ff  <= PCW'(NUM_MUTEXES);
         alloc_ff     <= '0;
      end else begin
         if (pool_we) begin
            pool_vld_ff[tail] <= 1'b1;
         end
         if (cmd.capture) begin
            pool_rd_vld_ff <= pool_vld_ff[pool_head_ff];
         end
         pool_head_ff <= pool_head_in;
         pool_cnt_ff  <= pool_cnt_in;
         if (alloc_set) begin
            alloc_ff[alloc_idx] <= 1'b1;
         end else if (alloc_clr) begin
            alloc_ff[alloc_idx] <= 1'b0;
         end
      end
   end

endmodule

// ===== src/rmt_ctrl.sv =====
`timescale 1ns / 1ps

module rmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   skid_full,
   input  rmt_pkg::dp_status_type status,
   output logic                   req_stall,
   output rmt_pkg::dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_WAKE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      ready;

   assign ready       = (state_ff == S_IDLE) && !skid_full;
   assign req_stall   = !ready;
   assign cmd.capture = req_valid && ready;
   assign cmd.exec    = (state_ff == S_EXEC);
   assign cmd.wake    = (state_ff == S_WAKE);
   assign cmd.load    = (cmd.exec && !status.need_wake) || cmd.wake;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = status.need_wake ? S_WAKE : S_IDLE;
         end
         S_WAKE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/recursive_mutex_table_top.sv =====
// result: computed in the exec state from the registered mutex entry table read, or, for an
// unlock that wakes a waiter, in the wake state from the registered wait queue store read,
// and registered in the output buffer; a new item is taken only back in idle, skid empty
// reset: synchronous; clears the sequencer, output valids, pool pointers and allocated bits
// no clearing pass: the block takes items as soon as reset is released
`timescale 1ns / 1ps

module recursive_mutex_table_top #(
   parameter int NUM_MUTEXES = rmt_pkg::NUM_MUTEXES_DEF,
   parameter int WAIT_DEPTH  = rmt_pkg::WAIT_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic [rmt_pkg::ID_W-1:0]      req_mutex_id,
   input  logic [rmt_pkg::PID_W-1:0]     req_requester_pid,
   input  logic                          req_requester_present,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [rmt_pkg::VALUE_W-1:0]   rsp_value,
   output logic                          rsp_woken_valid,
   output logic [rmt_pkg::PID_W-1:0]     rsp_woken_pid
);

   rmt_pkg::dp_cmd_type    cmd;
   rmt_pkg::dp_status_type status;
   rmt_pkg::result_type    res;
   rmt_pkg::result_type    rsp_res;
   logic                   skid_full;

   rmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .skid_full (skid_full),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   rmt_dp #(
      .NUM_MUTEXES (NUM_MUTEXES),
      .WAIT_DEPTH  (WAIT_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .req_operation         (req_operation),
      .req_mutex_id          (req_mutex_id),
      .req_requester_pid     (req_requester_pid),
      .req_requester_present (req_requester_present),
      .status                (status),
      .res                   (res)
   );

   rmt_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.load),
      .res_in    (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res),
      .skid_full (skid_full)
   );

   assign rsp_status      = rsp_res.status;
   assign rsp_value       = rsp_res.value;
   assign rsp_woken_valid = rsp_res.woken_valid;
   assign rsp_woken_pid   = rsp_res.woken_pid;

endmodule

// ===== src/rmt_checker.sv =====
`timescale 1ns / 1ps
`include "recursive_mutex_table_top_macros.svh"

module rmt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [1:0]                  req_operation,
   input logic [rmt_pkg::ID_W-1:0]    req_mutex_id,
   input logic [rmt_pkg::PID_W-1:0]   req_requester_pid,
   input logic                        req_requester_present,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [1:0]                  rsp_status,
   input logic [rmt_pkg::VALUE_W-1:0] rsp_value,
   input logic                        rsp_woken_valid,
   input logic [rmt_pkg::PID_W-1:0]   rsp_woken_pid
);

   `RMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_value) && $stable(rsp_woken_valid) && $stable(rsp_woken_pid), "stalled item changed")
   `RMT_ASSERT_NEXT(a_req_gap, clock, reset, req_valid && !req_stall, req_stall, "item accepted in back-to-back cycles")
   `RMT_ASSERT_SAME(a_wake_ok, clock, reset, rsp_valid && rsp_woken_valid, rsp_status == rmt_pkg::ST_OK && rsp_value == rmt_pkg::VALUE_W'(1), "hand-off without count of one")
   `RMT_ASSERT_SAME(a_err_clean, clock, reset, rsp_valid && rsp_status != rmt_pkg::ST_OK, rsp_value == '0 && !rsp_woken_valid && rsp_woken_pid == '0, "failed item carries data")

endmodule

bind recursive_mutex_table_top rmt_checker u_rmt_checker (.*);
